// ===== src/szc_pkg.sv =====
// Shared types and widths for the silhouette zero-crossing pipeline.
package szc_pkg;

  // Field and intermediate widths.
  localparam int FW  = 16;  // Q8.8 position, Q1.14 normal and view component
  localparam int PW  = 32;  // normal times view component
  localparam int DW  = 34;  // dot product, Q5.28
  localparam int MW  = 50;  // dot product times position
  localparam int NW  = 51;  // numerator d0*p1 - d1*p0
  localparam int EW  = 35;  // denominator d0 - d1
  localparam int XW  = 52;  // rounded dividend 2*|num| + den
  localparam int DVW = 36;  // divisor 2*|den|
  localparam int RW  = 53;  // partial remainder
  localparam int QW  = 17;  // quotient bits before saturation
  localparam int NUM_AXES = 3;

  // Configuration register indexes.
  localparam logic [1:0] REG_VIEW_X = 2'd0;
  localparam logic [1:0] REG_VIEW_Y = 2'd1;
  localparam logic [1:0] REG_VIEW_Z = 2'd2;

  typedef logic signed [FW-1:0] s16_t;
  typedef logic signed [PW-1:0] s32_t;
  typedef logic signed [DW-1:0] dot_t;
  typedef logic signed [MW-1:0] mul_t;

  // One beat in the divider chain, all three axes side by side.
  typedef struct packed {
    logic                          valid;
    logic [NUM_AXES-1:0]           neg;
    logic [NUM_AXES-1:0]           ovf;
    logic [DVW-1:0]                dvs;
    logic [NUM_AXES-1:0][RW-1:0]   rem;
    logic [NUM_AXES-1:0][QW-1:0]   quo;
  } div_t;

endpackage

// ===== src/szc_dot.sv =====
// Two stages: normal-by-view products, then the two dot products and the facing test.
module szc_dot import szc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  s16_t pa [NUM_AXES],
  input  s16_t pb [NUM_AXES],
  input  s16_t na [NUM_AXES],
  input  s16_t nb [NUM_AXES],
  input  s16_t view [NUM_AXES],
  output logic out_vld,
  output dot_t d0,
  output dot_t d1,
  output s16_t pa_o [NUM_AXES],
  output s16_t pb_o [NUM_AXES]
);

  logic vld1_r, vld2_r;
  s32_t proda_r [NUM_AXES];
  s32_t prodb_r [NUM_AXES];
  s16_t pa1_r [NUM_AXES];
  s16_t pb1_r [NUM_AXES];
  s16_t pa2_r [NUM_AXES];
  s16_t pb2_r [NUM_AXES];
  dot_t d0_r, d1_r, d0_nxt, d1_nxt;
  logic keep;

  // Stage one valid and stage two valid; edges with matching facing drop out here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r & keep;
    end
  end

  // Stage one: six products.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      proda_r[i] <= na[i] * view[i];
      prodb_r[i] <= nb[i] * view[i];
      pa1_r[i]   <= pa[i];
      pb1_r[i]   <= pb[i];
    end
  end

  // Stage two: exact sums.
  always_comb begin
    d0_nxt = DW'(proda_r[0]) + DW'(proda_r[1]) + DW'(proda_r[2]);
    d1_nxt = DW'(prodb_r[0]) + DW'(prodb_r[1]) + DW'(prodb_r[2]);
    keep   = d0_nxt[DW-1] ^ d1_nxt[DW-1];
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
    for (int i = 0; i < NUM_AXES; i++) begin
      pa2_r[i] <= pa1_r[i];
      pb2_r[i] <= pb1_r[i];
    end
  end

  assign out_vld = vld2_r;
  assign d0      = d0_r;
  assign d1      = d1_r;
  assign pa_o    = pa2_r;
  assign pb_o    = pb2_r;

endmodule

// ===== src/szc_num.sv =====
// Two stages: numerator products, then sign folding and the rounded dividend setup.
module szc_num import szc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  dot_t d0,
  input  dot_t d1,
  input  s16_t pa [NUM_AXES],
  input  s16_t pb [NUM_AXES],
  output div_t dout
);

  logic vld3_r;
  mul_t m0_r [NUM_AXES];
  mul_t m1_r [NUM_AXES];
  logic signed [EW-1:0] den_r;
  div_t dout_r, dout_nxt;

  // Stage three: d0*p1 and d1*p0 per axis, and the raw denominator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      m0_r[i] <= d0 * pb[i];
      m1_r[i] <= d1 * pa[i];
    end
    den_r <= EW'(d0) - EW'(d1);
  end

  // Stage four: make the divisor positive, take magnitudes, add half a divisor.
  always_comb begin
    logic signed [NUM_AXES-1:0][NW-1:0] num;
    logic [EW-1:0]  dabs;
    logic [NW-1:0]  mag;
    logic [XW-1:0]  xn;
    dout_nxt       = '0;
    dout_nxt.valid = vld3_r;
    dabs = den_r[EW-1] ? EW'(-den_r) : EW'(den_r);
    dout_nxt.dvs = {dabs, 1'b0};
    for (int i = 0; i < NUM_AXES; i++) begin
      num[i] = NW'(m0_r[i]) - NW'(m1_r[i]);
      if (den_r[EW-1]) begin
        num[i] = -num[i];
      end
      dout_nxt.neg[i] = num[i][NW-1];
      mag = num[i][NW-1] ? NW'(-num[i]) : NW'(num[i]);
      xn  = {mag, 1'b0} + XW'(dabs);
      dout_nxt.ovf[i] = {1'b0, xn} >= {dout_nxt.dvs, {QW{1'b0}}};
      dout_nxt.rem[i] = RW'(xn);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.valid <= 1'b0;
    end else begin
      dout_r.valid <= dout_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    dout_r.neg <= dout_nxt.neg;
    dout_r.ovf <= dout_nxt.ovf;
    dout_r.dvs <= dout_nxt.dvs;
    dout_r.rem <= dout_nxt.rem;
    dout_r.quo <= dout_nxt.quo;
  end

  assign dout = dout_r;

endmodule

// ===== src/szc_div_step.sv =====
// One restoring-division stage: yields one quotient bit per axis.
module szc_div_step import szc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  div_t din,
  output div_t dout
);

  div_t dout_r, dout_nxt;

  // Compare against the divisor aligned to the top quotient bit, then shift left.
  always_comb begin
    logic [RW-1:0] sub;
    logic          ge;
    dout_nxt = din;
    sub = RW'({din.dvs, {(QW-1){1'b0}}});
    for (int i = 0; i < NUM_AXES; i++) begin
      ge = din.rem[i] >= sub;
      dout_nxt.rem[i] = ge ? RW'((din.rem[i] - sub) << 1) : RW'(din.rem[i] << 1);
      dout_nxt.quo[i] = {din.quo[i][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.valid <= 1'b0;
    end else begin
      dout_r.valid <= dout_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    dout_r.neg <= dout_nxt.neg;
    dout_r.ovf <= dout_nxt.ovf;
    dout_r.dvs <= dout_nxt.dvs;
    dout_r.rem <= dout_nxt.rem;
    dout_r.quo <= dout_nxt.quo;
  end

  assign dout = dout_r;

endmodule

// ===== src/silhouette_zero_crossing_point_core.sv =====
// Top level: view registers, the dot, numerator and divider pipeline, and the result register.
//
//   channel  | handshake                 | beat
//   ---------+---------------------------+---------------------------------------
//   input    | start, busy               | in_end_a/b_xyz, in_norm_a/b_xyz
//   result   | out_valid (strobe)        | out_cross_x/y/z
//   config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// A new edge is taken in every cycle; busy is always low. A result passes through
// two dot stages, two numerator stages, 17 divider stages (one quotient bit each)
// and the output register. Edges whose endpoints face the same way leave no result.
// Reset clears the valid bits and loads the view registers. The receiver cannot
// stall, so nothing in the pipeline ever waits.
module silhouette_zero_crossing_point_core import szc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_end_a_x,
  input  logic [15:0] in_end_a_y,
  input  logic [15:0] in_end_a_z,
  input  logic [15:0] in_end_b_x,
  input  logic [15:0] in_end_b_y,
  input  logic [15:0] in_end_b_z,
  input  logic [15:0] in_norm_a_x,
  input  logic [15:0] in_norm_a_y,
  input  logic [15:0] in_norm_a_z,
  input  logic [15:0] in_norm_b_x,
  input  logic [15:0] in_norm_b_y,
  input  logic [15:0] in_norm_b_z,
  output logic        out_valid,
  output logic [15:0] out_cross_x,
  output logic [15:0] out_cross_y,
  output logic [15:0] out_cross_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  s16_t view_r [NUM_AXES];
  s16_t pa [NUM_AXES];
  s16_t pb [NUM_AXES];
  s16_t na [NUM_AXES];
  s16_t nb [NUM_AXES];
  s16_t pa2 [NUM_AXES];
  s16_t pb2 [NUM_AXES];
  logic dot_vld;
  dot_t d0, d1;
  div_t chain [QW+1];
  logic out_valid_r;
  logic [NUM_AXES-1:0][FW-1:0] cross_r, cross_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // View direction registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r[0] <= '0;
      view_r[1] <= '0;
      view_r[2] <= -16'sd16384;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VIEW_X: view_r[0] <= cfg_data;
        REG_VIEW_Y: view_r[1] <= cfg_data;
        REG_VIEW_Z: view_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pa = '{in_end_a_x, in_end_a_y, in_end_a_z};
  assign pb = '{in_end_b_x, in_end_b_y, in_end_b_z};
  assign na = '{in_norm_a_x, in_norm_a_y, in_norm_a_z};
  assign nb = '{in_norm_b_x, in_norm_b_y, in_norm_b_z};

  szc_dot u_dot (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start & ~busy),
    .pa     (pa),
    .pb     (pb),
    .na     (na),
    .nb     (nb),
    .view   (view_r),
    .out_vld(dot_vld),
    .d0     (d0),
    .d1     (d1),
    .pa_o   (pa2),
    .pb_o   (pb2)
  );

  szc_num u_num (
    .clk   (clk),
    .rst_n (rst_n),
    .in_vld(dot_vld),
    .d0    (d0),
    .d1    (d1),
    .pa    (pa2),
    .pb    (pb2),
    .dout  (chain[0])
  );

  // Divider chain, one quotient bit per stage.
  for (genvar k = 0; k < QW; k++) begin : g_div
    szc_div_step u_step (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  // Apply sign and saturate to Q8.8.
  always_comb begin
    logic [QW-1:0] q;
    for (int i = 0; i < NUM_AXES; i++) begin
      q = chain[QW].quo[i];
      if (chain[QW].neg[i]) begin
        cross_nxt[i] = (chain[QW].ovf[i] || q > QW'(32768)) ? 16'h8000 : FW'(-q);
      end else begin
        cross_nxt[i] = (chain[QW].ovf[i] || q > QW'(32767)) ? 16'h7fff : FW'(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    cross_r <= cross_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_cross_x = cross_r[0];
  assign out_cross_y = cross_r[1];
  assign out_cross_z = cross_r[2];

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the silhouette zero-crossing point core.
`timescale 1ns / 100ps

module testbench;
  import szc_pkg::*;

  localparam int PIPE_DEPTH = 22;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [15:0] pa[3];
    logic [15:0] pb[3];
    logic [15:0] na[3];
    logic [15:0] nb[3];
  } mesh_edge_t;

  typedef struct {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
  } cross_pt_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [15:0] in_end_a_x, in_end_a_y, in_end_a_z;
  logic [15:0] in_end_b_x, in_end_b_y, in_end_b_z;
  logic [15:0] in_norm_a_x, in_norm_a_y, in_norm_a_z;
  logic [15:0] in_norm_b_x, in_norm_b_y, in_norm_b_z;
  logic out_valid;
  logic [15:0] out_cross_x, out_cross_y, out_cross_z;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  // Local copy of the view vector and the queue of expected crossing points.
  logic signed [15:0] view_vec[3];
  cross_pt_t expected_points[$];
  int error_count;
  int edges_sent;
  int points_seen;
  int cycle_count;
  bit idle_gaps;

  silhouette_zero_crossing_point_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_end_a_x(in_end_a_x), .in_end_a_y(in_end_a_y), .in_end_a_z(in_end_a_z),
    .in_end_b_x(in_end_b_x), .in_end_b_y(in_end_b_y), .in_end_b_z(in_end_b_z),
    .in_norm_a_x(in_norm_a_x), .in_norm_a_y(in_norm_a_y), .in_norm_a_z(in_norm_a_z),
    .in_norm_b_x(in_norm_b_x), .in_norm_b_y(in_norm_b_y), .in_norm_b_z(in_norm_b_z),
    .out_valid(out_valid), .out_cross_x(out_cross_x), .out_cross_y(out_cross_y),
    .out_cross_z(out_cross_z), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Cycle counter with a hard timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Normal dotted with the view vector, exact.
  function automatic longint facing_dot(logic [15:0] n[3]);
    longint acc;
    acc = 0;
    for (int i = 0; i < 3; i++)
      acc += longint'($signed(n[i])) * longint'(view_vec[i]);
    return acc;
  endfunction

  // Rounded, saturated quotient for one axis.
  function automatic logic [15:0] axis_crossing(longint p0, longint p1, longint d0,
                                                longint d1);
    longint num;
    longint den;
    longint mag;
    num = d0 * p1 - d1 * p0;
    den = d0 - d1;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    mag = (num < 0) ? -num : num;
    mag = (2 * mag + den) / (2 * den);
    if (num < 0) mag = -mag;
    if (mag > 32767) mag = 32767;
    if (mag < -32768) mag = -32768;
    return mag[15:0];
  endfunction

  // Queue the crossing point an edge produces, if any.
  function automatic void predict_crossing(mesh_edge_t e);
    longint d0, d1;
    logic [15:0] r[3];
    cross_pt_t pt;
    d0 = facing_dot(e.na);
    d1 = facing_dot(e.nb);
    if ((d0 < 0) == (d1 < 0)) return;
    for (int i = 0; i < 3; i++)
      r[i] = axis_crossing($signed(e.pa[i]), $signed(e.pb[i]), d0, d1);
    pt.px = r[0];
    pt.py = r[1];
    pt.pz = r[2];
    expected_points.insert(expected_points.size(), pt);
  endfunction

  // Compare every result beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      points_seen++;
      if (expected_points.size() == 0) begin
        $display("%0t unexpected point: expected none, actual %h %h %h", $time,
                 out_cross_x, out_cross_y, out_cross_z);
        error_count++;
      end else begin
        cross_pt_t want;
        want = expected_points.pop_front();
        if (want.px !== out_cross_x) begin
          $display("%0t cross_x: expected %h, actual %h", $time, want.px, out_cross_x);
          error_count++;
        end
        if (want.py !== out_cross_y) begin
          $display("%0t cross_y: expected %h, actual %h", $time, want.py, out_cross_y);
          error_count++;
        end
        if (want.pz !== out_cross_z) begin
          $display("%0t cross_z: expected %h, actual %h", $time, want.pz, out_cross_z);
          error_count++;
        end
      end
    end
  end

  // Send one edge; start stays high across back-to-back beats.
  task automatic send_edge(mesh_edge_t e);
    if (idle_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start <= 1'b1;
    in_end_a_x <= e.pa[0];
    in_end_a_y <= e.pa[1];
    in_end_a_z <= e.pa[2];
    in_end_b_x <= e.pb[0];
    in_end_b_y <= e.pb[1];
    in_end_b_z <= e.pb[2];
    in_norm_a_x <= e.na[0];
    in_norm_a_y <= e.na[1];
    in_norm_a_z <= e.na[2];
    in_norm_b_x <= e.nb[0];
    in_norm_b_y <= e.nb[1];
    in_norm_b_z <= e.nb[2];
    do @(posedge clk); while (busy);
    predict_crossing(e);
    edges_sent++;
  endtask

  // Drain the pipeline, then write one view register.
  task automatic write_view(logic [1:0] idx, logic [15:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    view_vec[idx] = val;
  endtask

  task automatic set_view(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz);
    write_view(REG_VIEW_X, vx);
    write_view(REG_VIEW_Y, vy);
    write_view(REG_VIEW_Z, vz);
  endtask

  function automatic logic [15:0] rand_normal();
    case ($urandom_range(0, 5))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mesh_edge_t rand_edge();
    mesh_edge_t e;
    for (int i = 0; i < 3; i++) begin
      e.pa[i] = rand_pos();
      e.pb[i] = rand_pos();
      e.na[i] = rand_normal();
      e.nb[i] = rand_normal();
    end
    // Mostly force the endpoints to face opposite ways so crossings are common.
    if ($urandom_range(0, 3) != 0) begin
      longint da, db;
      da = facing_dot(e.na);
      db = facing_dot(e.nb);
      if ((da < 0) == (db < 0))
        for (int i = 0; i < 3; i++) e.nb[i] = -$signed(e.nb[i]);
    end
    return e;
  endfunction

  function automatic mesh_edge_t make_edge(logic [15:0] p, logic [15:0] q, logic [15:0] nza,
                                           logic [15:0] nzb);
    mesh_edge_t e;
    for (int i = 0; i < 3; i++) begin
      e.pa[i] = p;
      e.pb[i] = q;
      e.na[i] = 16'h0;
      e.nb[i] = 16'h0;
    end
    e.na[2] = nza;
    e.nb[2] = nzb;
    return e;
  endfunction

  // Extremes at the reset view: one side front-facing, both, neither, zero dot.
  task automatic test_directed();
    send_edge(make_edge(16'h7FFF, 16'h8000, 16'h4000, 16'hC000));
    send_edge(make_edge(16'h8000, 16'h7FFF, 16'hC000, 16'h4000));
    send_edge(make_edge(16'h0100, 16'hFF00, 16'h4000, 16'h4000));
    send_edge(make_edge(16'h0100, 16'hFF00, 16'hC000, 16'hC000));
    send_edge(make_edge(16'h0100, 16'hFF00, 16'h4000, 16'h0000));
    send_edge(make_edge(16'h0000, 16'h0300, 16'h0000, 16'hC000));
    send_edge(make_edge(16'h0001, 16'h0002, 16'h0001, 16'hFFFF));
    send_edge(make_edge(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000));
    send_edge(make_edge(16'h1234, 16'hEDCB, 16'h8000, 16'h7FFF));
    send_edge(make_edge(16'h0000, 16'h0000, 16'hFFFF, 16'h0001));
    // Ties in the rounding: crossing exactly half-way between adjacent codes.
    send_edge(make_edge(16'h0001, 16'h0002, 16'h2000, 16'hE000));
    send_edge(make_edge(16'hFFFF, 16'hFFFE, 16'h2000, 16'hE000));
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) send_edge(rand_edge());
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_VIEW_X;
    cfg_data = '0;
    {in_end_a_x, in_end_a_y, in_end_a_z, in_end_b_x, in_end_b_y, in_end_b_z} = '0;
    {in_norm_a_x, in_norm_a_y, in_norm_a_z, in_norm_b_x, in_norm_b_y, in_norm_b_z} = '0;
    view_vec[0] = 16'sh0000;
    view_vec[1] = 16'sh0000;
    view_vec[2] = 16'shC000;
    error_count = 0;
    edges_sent = 0;
    points_seen = 0;
    cycle_count = 0;
    idle_gaps = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    idle_gaps = 1'b1;
    test_random(300);
    set_view(16'h4000, 16'h0000, 16'h0000);
    test_random(250);
    set_view(16'hC000, 16'h4000, 16'h4000);
    test_random(250);
    set_view(16'h8000, 16'h7FFF, 16'hFFFF);
    test_directed();
    test_random(250);
    set_view(16'h2D41, 16'hD2BF, 16'h1000);
    test_random(250);
    idle_gaps = 1'b0;
    test_random(230);

    start <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    $display("Sent %0d edges over five view vectors; %0d crossing points checked.",
             edges_sent, points_seen);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/szc_pkg.sv
src/szc_dot.sv
src/szc_num.sv
src/szc_div_step.sv
src/silhouette_zero_crossing_point_core.sv
tb/testbench.sv
